// ----- src/frt_pkg.sv -----
// Shared types and constants for the fragment reassembly tracker.
package frt_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int MAX_FRAGS_DEF = 32;
    localparam int QDEPTH        = 2;

    localparam logic [1:0] CFG_MAX_FRAGS = 2'd0;
    localparam logic [1:0] CFG_MAX_PEND  = 2'd1;
    localparam logic [1:0] CFG_MAX_BYTES = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT   = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_INDEX = 3'd1;
    localparam logic [2:0] ST_TOO_MANY  = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_MISMATCH  = 3'd4;
    localparam logic [2:0] ST_DUP       = 3'd5;
    localparam logic [2:0] ST_TOO_LARGE = 3'd6;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAN = 1'b1;

    typedef struct packed {
        logic        command;
        logic [31:0] msg_id;
        logic [15:0] frag_index;
        logic [15:0] frag_total;
        logic [15:0] payload_len;
        logic [31:0] time_ms;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        completed;
        logic [31:0] done_msg_id;
        logic [23:0] done_bytes;
        logic [4:0]  expired_now;
        logic [31:0] seen_count;
        logic [31:0] assembled_count;
        logic [31:0] expired_count;
    } t_out_item;

    // classified request handed from front to back
    typedef struct packed {
        logic        command;
        logic        pre_fail;
        logic [2:0]  pre_status;
        logic [31:0] msg_id;
        logic [15:0] frag_index;
        logic [15:0] frag_total;
        logic [15:0] payload_len;
        logic [31:0] time_ms;
    } t_req;

endpackage

// ----- src/frt_front.sv -----
// Front: accepts requests, runs header checks, queues them for the table.
module frt_front #(
    parameter int MAX_FRAGS = frt_pkg::MAX_FRAGS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  frt_pkg::t_in_item i_item,
    input  logic [5:0]        i_max_frags,
    output logic              o_req_valid,
    input  logic              i_req_pop,
    output frt_pkg::t_req     o_req
);
    localparam int QW = $clog2(frt_pkg::QDEPTH);

    frt_pkg::t_req r_q [frt_pkg::QDEPTH];
    logic [QW-1:0] r_wp, r_rp;
    logic [QW:0]   r_cnt;
    frt_pkg::t_req n_req;
    logic [6:0]    limit;
    logic          push;

    assign o_stall     = (r_cnt == (QW+1)'(frt_pkg::QDEPTH));
    assign push        = i_valid && !o_stall;
    assign o_req_valid = (r_cnt != '0);
    assign o_req       = r_q[r_rp];

    always_comb begin
        limit = (7'(i_max_frags) > 7'(MAX_FRAGS)) ? 7'(MAX_FRAGS) : 7'(i_max_frags);
        n_req.command     = i_item.command;
        n_req.msg_id      = i_item.msg_id;
        n_req.frag_index  = i_item.frag_index;
        n_req.frag_total  = i_item.frag_total;
        n_req.payload_len = i_item.payload_len;
        n_req.time_ms     = i_item.time_ms;
        n_req.pre_fail    = 1'b0;
        n_req.pre_status  = frt_pkg::ST_OK;
        if (i_item.frag_total == '0 || i_item.frag_index >= i_item.frag_total) begin
            n_req.pre_fail   = 1'b1;
            n_req.pre_status = frt_pkg::ST_BAD_INDEX;
        end else if (i_item.frag_total > 16'(limit)) begin
            n_req.pre_fail   = 1'b1;
            n_req.pre_status = frt_pkg::ST_TOO_MANY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_req;
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == QW'(frt_pkg::QDEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_req_pop) r_rp <= (r_rp == QW'(frt_pkg::QDEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (QW+1)'(push) - (QW+1)'(i_req_pop);
        end
    end
endmodule

// ----- src/frt_back.sv -----
// Back: slot table, id match, update and cleanup walk, output register.
module frt_back #(
    parameter int SLOTS     = frt_pkg::SLOTS_DEF,
    parameter int MAX_FRAGS = frt_pkg::MAX_FRAGS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_pop,
    input  frt_pkg::t_req      i_req,
    input  logic [4:0]         i_max_pend,
    input  logic [23:0]        i_max_bytes,
    input  logic [31:0]        i_timeout,
    output logic               o_valid,
    input  logic               i_stall,
    output frt_pkg::t_out_item o_item
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int FW = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
    localparam int TW = $clog2(MAX_FRAGS + 1);

    typedef enum logic [1:0] {S_IDLE, S_ADD, S_CLEAN, S_OUT} t_state;

    t_state          r_state;
    logic [SLOTS-1:0] r_valid;
    logic [31:0]     r_id    [SLOTS];
    logic [TW-1:0]   r_total [SLOTS];
    logic [MAX_FRAGS-1:0] r_map [SLOTS];
    logic [TW-1:0]   r_num   [SLOTS];
    logic [24:0]     r_sum   [SLOTS];
    logic [31:0]     r_start [SLOTS];
    logic [31:0]     r_seen, r_asm, r_exp;
    frt_pkg::t_req   r_req;
    logic            r_hit, r_free_ok;
    logic [SW-1:0]   r_hit_idx, r_free_idx;
    logic [SW-1:0]   r_walk;
    logic [4:0]      r_freed;
    logic            r_ovalid;
    frt_pkg::t_out_item r_out;

    logic            hit, free_ok;
    logic [SW-1:0]   hit_idx, free_idx;
    logic [CW-1:0]   used;
    logic [SW-1:0]   s;
    logic            newslot;
    logic [24:0]     nsum;
    logic [TW-1:0]   ntot;

    assign o_valid   = r_ovalid;
    assign o_item    = r_out;
    assign o_req_pop = (r_state == S_IDLE) && i_req_valid && (!r_ovalid || !i_stall);

    // priority match and free search on the queued request
    always_comb begin
        hit = 1'b0; hit_idx = '0; free_ok = 1'b0; free_idx = '0; used = '0;
        for (int k = SLOTS-1; k >= 0; k--) begin
            if (r_valid[k] && r_id[k] == i_req.msg_id) begin
                hit = 1'b1; hit_idx = SW'(k);
            end
            if (!r_valid[k]) begin
                free_ok = 1'b1; free_idx = SW'(k);
            end
        end
        for (int k = 0; k < SLOTS; k++) used = used + CW'(r_valid[k]);
        if (32'(used) >= 32'(i_max_pend)) free_ok = 1'b0;
    end

    always_comb begin
        newslot = !r_hit;
        s       = r_hit ? r_hit_idx : r_free_idx;
        ntot    = TW'(r_req.frag_total);
        nsum    = (newslot ? 25'd0 : r_sum[s]) + 25'(r_req.payload_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_seen   <= '0;
            r_asm    <= '0;
            r_exp    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_req_pop) begin
                        r_req      <= i_req;
                        r_hit      <= hit;
                        r_hit_idx  <= hit_idx;
                        r_free_ok  <= free_ok;
                        r_free_idx <= free_idx;
                        r_walk     <= '0;
                        r_freed    <= '0;
                        r_state    <= (i_req.command == frt_pkg::CMD_CLEAN) ? S_CLEAN : S_ADD;
                    end
                end
                S_ADD: begin
                    r_out.status      <= frt_pkg::ST_OK;
                    r_out.completed   <= 1'b0;
                    r_out.done_msg_id <= '0;
                    r_out.done_bytes  <= '0;
                    r_out.expired_now <= '0;
                    r_out.seen_count  <= r_seen + 1'b1;
                    r_out.assembled_count <= r_asm;
                    r_out.expired_count   <= r_exp;
                    r_seen <= r_seen + 1'b1;
                    if (r_req.pre_fail) begin
                        r_out.status <= r_req.pre_status;
                    end else if (newslot && !r_free_ok) begin
                        r_out.status <= frt_pkg::ST_FULL;
                    end else begin
                        if (newslot) begin
                            r_valid[s] <= 1'b1;
                            r_id[s]    <= r_req.msg_id;
                            r_total[s] <= ntot;
                            r_start[s] <= r_req.time_ms;
                            r_map[s]   <= '0;
                            r_num[s]   <= '0;
                            r_sum[s]   <= '0;
                        end
                        if (!newslot && r_total[s] != ntot) begin
                            r_out.status <= frt_pkg::ST_MISMATCH;
                        end else if (!newslot && r_map[s][FW'(r_req.frag_index)]) begin
                            r_out.status <= frt_pkg::ST_DUP;
                        end else if (nsum > 25'(i_max_bytes)) begin
                            r_out.status <= frt_pkg::ST_TOO_LARGE;
                        end else begin
                            r_map[s][FW'(r_req.frag_index)] <= 1'b1;
                            r_num[s] <= (newslot ? '0 : r_num[s]) + 1'b1;
                            r_sum[s] <= nsum;
                            if (((newslot ? '0 : r_num[s]) + 1'b1) == ntot) begin
                                r_valid[s]        <= 1'b0;
                                r_out.completed   <= 1'b1;
                                r_out.done_msg_id <= r_req.msg_id;
                                r_out.done_bytes  <= nsum[23:0];
                                r_out.assembled_count <= r_asm + 1'b1;
                                r_asm <= r_asm + 1'b1;
                            end
                        end
                    end
                    r_state <= S_OUT;
                end
                S_CLEAN: begin
                    // one slot a cycle
                    if (r_valid[r_walk] &&
                        (r_req.time_ms - r_start[r_walk]) > i_timeout) begin
                        r_valid[r_walk] <= 1'b0;
                        r_freed <= r_freed + 1'b1;
                        r_exp   <= r_exp + 1'b1;
                    end
                    if (32'(r_walk) == SLOTS-1) begin
                        r_state <= S_OUT;
                    end else begin
                        r_walk <= r_walk + 1'b1;
                    end
                end
                S_OUT: begin
                    if (r_req.command == frt_pkg::CMD_CLEAN) begin
                        r_out.status      <= frt_pkg::ST_OK;
                        r_out.completed   <= 1'b0;
                        r_out.done_msg_id <= '0;
                        r_out.done_bytes  <= '0;
                        r_out.expired_now <= r_freed;
                        r_out.seen_count  <= r_seen;
                        r_out.assembled_count <= r_asm;
                        r_out.expired_count   <= r_exp;
                    end
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- src/fragment_reassembly_tracker.sv -----
// Add request: with the back idle, o_valid rises after the pop, update and output states.
// The back pops no new request until it has run the table update sequence of the last one.
// Cleanup walks one slot per cycle.
// Synchronous active-low reset clears slot valid bits and counters, restores config defaults.
// A 2-entry queue decouples request intake from the table.
module fragment_reassembly_tracker #(
    parameter int SLOTS     = frt_pkg::SLOTS_DEF,
    parameter int MAX_FRAGS = frt_pkg::MAX_FRAGS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  frt_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output frt_pkg::t_out_item o_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    logic [5:0]  r_max_frags;
    logic [4:0]  r_max_pend;
    logic [23:0] r_max_bytes;
    logic [31:0] r_timeout;
    logic          req_valid, req_pop;
    frt_pkg::t_req req;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frags <= 6'd32;
            r_max_pend  <= 5'd16;
            r_max_bytes <= 24'd65536;
            r_timeout   <= 32'd5000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                frt_pkg::CFG_MAX_FRAGS: r_max_frags <= i_cfg_data[5:0];
                frt_pkg::CFG_MAX_PEND:  r_max_pend  <= i_cfg_data[4:0];
                frt_pkg::CFG_MAX_BYTES: r_max_bytes <= i_cfg_data[23:0];
                frt_pkg::CFG_TIMEOUT:   r_timeout   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    frt_front #(.MAX_FRAGS(MAX_FRAGS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .i_max_frags(r_max_frags),
        .o_req_valid(req_valid), .i_req_pop(req_pop), .o_req(req)
    );

    frt_back #(.SLOTS(SLOTS), .MAX_FRAGS(MAX_FRAGS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(req_valid), .o_req_pop(req_pop), .i_req(req),
        .i_max_pend(r_max_pend), .i_max_bytes(r_max_bytes), .i_timeout(r_timeout),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );
endmodule

// ----- test/frt_checker.sv -----
`timescale 1ns / 1ps
// Checker for the fragment reassembly tracker: table predictor and result compare.
module frt_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall,
    input  frt_pkg::t_in_item  i_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  frt_pkg::t_out_item i_out_item,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending
);
    localparam int NSLOT = frt_pkg::SLOTS_DEF;

    logic [5:0]  lim_frags;
    logic [4:0]  lim_pend;
    logic [23:0] lim_bytes;
    logic [31:0] tmo;

    logic        tv     [NSLOT];
    logic [31:0] tid    [NSLOT];
    logic [15:0] ttotal [NSLOT];
    logic [31:0] tmap   [NSLOT];
    logic [5:0]  tnum   [NSLOT];
    logic [24:0] tbytes [NSLOT];
    logic [31:0] tstart [NSLOT];
    logic [31:0] n_seen, n_done, n_exp;

    frt_pkg::t_out_item expected_results[$];

    assign o_pending = expected_results.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        o_errors++;
    endtask

    function automatic int count_live();
        int n;
        n = 0;
        for (int k = 0; k < NSLOT; k++) if (tv[k]) n++;
        return n;
    endfunction

    task automatic predict_request(input frt_pkg::t_in_item it);
        frt_pkg::t_out_item r;
        int s, lim;
        logic [24:0] sum;
        r = '0;
        s = -1;
        if (it.command == frt_pkg::CMD_CLEAN) begin
            for (int k = 0; k < NSLOT; k++) begin
                if (tv[k] && (it.time_ms - tstart[k]) > tmo) begin
                    tv[k] = 1'b0;
                    r.expired_now++;
                    n_exp++;
                end
            end
        end else begin
            n_seen++;
            lim = (lim_frags > frt_pkg::MAX_FRAGS_DEF) ? frt_pkg::MAX_FRAGS_DEF : lim_frags;
            if (it.frag_total == 0 || it.frag_index >= it.frag_total) begin
                r.status = frt_pkg::ST_BAD_INDEX;
            end else if (it.frag_total > lim) begin
                r.status = frt_pkg::ST_TOO_MANY;
            end else begin
                for (int k = NSLOT - 1; k >= 0; k--)
                    if (tv[k] && tid[k] == it.msg_id) s = k;
                if (s < 0) begin
                    if (count_live() >= lim_pend) begin
                        r.status = frt_pkg::ST_FULL;
                    end else begin
                        for (int k = NSLOT - 1; k >= 0; k--) if (!tv[k]) s = k;
                        if (s < 0) begin
                            r.status = frt_pkg::ST_FULL;
                        end else begin
                            tv[s] = 1'b1;
                            tid[s] = it.msg_id;
                            ttotal[s] = it.frag_total;
                            tmap[s] = '0;
                            tnum[s] = '0;
                            tbytes[s] = '0;
                            tstart[s] = it.time_ms;
                        end
                    end
                end
                if (s >= 0) begin
                    sum = tbytes[s] + it.payload_len;
                    if (ttotal[s] != it.frag_total) begin
                        r.status = frt_pkg::ST_MISMATCH;
                    end else if (tmap[s][it.frag_index[4:0]]) begin
                        r.status = frt_pkg::ST_DUP;
                    end else if (sum > lim_bytes) begin
                        r.status = frt_pkg::ST_TOO_LARGE;
                    end else begin
                        tmap[s][it.frag_index[4:0]] = 1'b1;
                        tnum[s]++;
                        tbytes[s] = sum;
                        if (tnum[s] == ttotal[s]) begin
                            r.completed = 1'b1;
                            r.done_msg_id = it.msg_id;
                            r.done_bytes = sum[23:0];
                            tv[s] = 1'b0;
                            n_done++;
                        end
                    end
                end
            end
        end
        r.seen_count = n_seen;
        r.assembled_count = n_done;
        r.expired_count = n_exp;
        expected_results.push_back(r);
    endtask

    task automatic compare_result(input frt_pkg::t_out_item g);
        frt_pkg::t_out_item w;
        if (expected_results.size() == 0) begin
            report("unexpected result", 32'(g.status), 32'hx);
            return;
        end
        w = expected_results.pop_front();
        if (g.status != w.status) report("status", 32'(g.status), 32'(w.status));
        if (g.completed != w.completed) report("completed", 32'(g.completed), 32'(w.completed));
        if (g.done_msg_id != w.done_msg_id) report("done_msg_id", g.done_msg_id, w.done_msg_id);
        if (g.done_bytes != w.done_bytes) report("done_bytes", 32'(g.done_bytes), 32'(w.done_bytes));
        if (g.expired_now != w.expired_now)
            report("expired_now", 32'(g.expired_now), 32'(w.expired_now));
        if (g.seen_count != w.seen_count) report("seen_count", g.seen_count, w.seen_count);
        if (g.assembled_count != w.assembled_count)
            report("assembled_count", g.assembled_count, w.assembled_count);
        if (g.expired_count != w.expired_count)
            report("expired_count", g.expired_count, w.expired_count);
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lim_frags = 6'd32;
            lim_pend = 5'd16;
            lim_bytes = 24'd65536;
            tmo = 32'd5000;
            for (int k = 0; k < NSLOT; k++) tv[k] = 1'b0;
            n_seen = '0;
            n_done = '0;
            n_exp = '0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) compare_result(i_out_item);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    frt_pkg::CFG_MAX_FRAGS: lim_frags = i_cfg_data[5:0];
                    frt_pkg::CFG_MAX_PEND:  lim_pend = i_cfg_data[4:0];
                    frt_pkg::CFG_MAX_BYTES: lim_bytes = i_cfg_data[23:0];
                    frt_pkg::CFG_TIMEOUT:   tmo = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !i_stall) predict_request(i_item);
        end
    end

    final begin
        if (expected_results.size() != 0) $display("mismatch: results left over at end");
    end
endmodule

// ----- test/tb_fragment_reassembly_tracker.sv -----
`timescale 1ns / 1ps
// Testbench top for the fragment reassembly tracker: stimulus, config and verdict.
module tb_fragment_reassembly_tracker;
    localparam int IDLE_LIMIT = 4000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    frt_pkg::t_in_item  in_item = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    frt_pkg::t_out_item out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int          errors;
    int          pending;
    int          idle_cycles = 0;
    logic [31:0] clock_ms = 32'd100;
    logic [31:0] id_base = '0;

    always #1 clk = ~clk;

    fragment_reassembly_tracker u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_item(in_item),
        .o_valid(out_valid), .i_stall(out_stall), .o_item(out_item),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    frt_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_stall(in_stall), .i_item(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_item(out_item),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver stall pattern: quiet stretches alternate with random stalling
    always @(posedge clk) begin
        int phase;
        phase = int'(($time / 400) % 3);
        if (phase == 0) out_stall <= 1'b0;
        else if (phase == 1) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= ($urandom_range(0, 1) == 0);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_fragment_reassembly_tracker NOT OK");
                $finish;
            end
        end
    end

    int burst_left = 0;

    // valid stays high inside a burst; this task drops it only for a gap
    task automatic send_request(input frt_pkg::t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 4);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic add_frag(input logic [31:0] id, input logic [15:0] idx,
                            input logic [15:0] tot, input logic [15:0] len);
        frt_pkg::t_in_item it;
        it = '0;
        it.command = frt_pkg::CMD_ADD;
        it.msg_id = id;
        it.frag_index = idx;
        it.frag_total = tot;
        it.payload_len = len;
        it.time_ms = clock_ms;
        send_request(it);
    endtask

    task automatic clean_up(input logic [31:0] now);
        frt_pkg::t_in_item it;
        it = '0;
        it.command = frt_pkg::CMD_CLEAN;
        it.time_ms = now;
        it.msg_id = $urandom;
        send_request(it);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        in_valid <= 1'b0;
        repeat (24) @(posedge clk);
        while (pending != 0) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one message in shuffled order, sometimes with a duplicate or a bad total
    task automatic send_message(input logic [15:0] tot, input int noisy);
        logic [15:0] order[$];
        logic [31:0] id;
        int j;
        id = id_base + $urandom_range(0, 40);
        for (int k = 0; k < tot; k++) order.push_back(16'(k));
        order.shuffle();
        foreach (order[k]) begin
            clock_ms += $urandom_range(0, 50);
            j = $urandom_range(0, 15);
            if (noisy && j == 0)
                add_frag(id, order[k], tot + 16'd1, 16'($urandom_range(0, 3000)));
            else if (noisy && j == 1 && k > 0)
                add_frag(id, order[k - 1], tot, 16'($urandom_range(0, 3000)));
            add_frag(id, order[k], tot,
                     (j == 2) ? 16'($urandom) : 16'($urandom_range(0, 3000)));
        end
    endtask

    initial begin
        frt_pkg::t_in_item it;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: each status, completion, limits and cleanup
        add_frag(32'hFFFF_FFFF, 16'd0, 16'd0, 16'd5);
        add_frag(32'h1, 16'd3, 16'd3, 16'd5);
        add_frag(32'h1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_frag(32'h1, 16'd0, 16'd33, 16'd1);
        add_frag(32'h2, 16'd0, 16'd1, 16'hFFFF);
        add_frag(32'h3, 16'd31, 16'd32, 16'd10);
        add_frag(32'h3, 16'd31, 16'd32, 16'd10);
        add_frag(32'h3, 16'd0, 16'd31, 16'd10);
        add_frag(32'h4, 16'd0, 16'd2, 16'hFFFF);
        add_frag(32'h4, 16'd1, 16'd2, 16'hFFFF);
        add_frag(32'h0, 16'd0, 16'd2, 16'd0);
        clean_up(clock_ms + 5000);
        clean_up(clock_ms + 5001);
        write_reg(frt_pkg::CFG_MAX_PEND, 32'd2);
        add_frag(32'h10, 16'd0, 16'd2, 16'd1);
        add_frag(32'h11, 16'd0, 16'd2, 16'd1);
        add_frag(32'h12, 16'd0, 16'd2, 16'd1);
        write_reg(frt_pkg::CFG_MAX_PEND, 32'd31);
        for (int k = 0; k < 16; k++) add_frag(32'h100 + k, 16'd0, 16'd2, 16'd1);
        clean_up(32'hFFFF_FFFF);
        write_reg(frt_pkg::CFG_MAX_BYTES, 32'h00FF_FFFF);
        write_reg(frt_pkg::CFG_MAX_FRAGS, 32'd63);
        add_frag(32'h20, 16'd40, 16'd41, 16'd1);
        add_frag(32'h20, 16'd0, 16'd1, 16'hFFFF);
        write_reg(frt_pkg::CFG_TIMEOUT, 32'hFFFF_FFFF);
        clean_up(32'h0);
        write_reg(frt_pkg::CFG_TIMEOUT, 32'd0);
        clean_up(clock_ms + 1);
        write_reg(frt_pkg::CFG_MAX_FRAGS, 32'd0);
        add_frag(32'h21, 16'd0, 16'd1, 16'd1);

        // random phases over several settings
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(frt_pkg::CFG_MAX_FRAGS, (ph == 0) ? 32'd1 : $urandom_range(2, 63));
            write_reg(frt_pkg::CFG_MAX_PEND, (ph == 1) ? 32'd0 : $urandom_range(1, 31));
            write_reg(frt_pkg::CFG_MAX_BYTES, (ph == 2) ? 32'd0 :
                      (ph == 3) ? $urandom : $urandom_range(2000, 80000));
            write_reg(frt_pkg::CFG_TIMEOUT, (ph == 4) ? $urandom : $urandom_range(100, 2000));
            id_base = $urandom;
            for (int m = 0; m < 45; m++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        it = '0;
                        it.command = ($urandom_range(0, 1) == 1);
                        it.msg_id = id_base + $urandom_range(0, 40);
                        it.frag_index = 16'($urandom);
                        it.frag_total = 16'($urandom);
                        it.payload_len = 16'($urandom);
                        it.time_ms = (m % 2) ? $urandom : clock_ms;
                        if (it.command == frt_pkg::CMD_ADD) send_request(it);
                        else clean_up(it.time_ms);
                        it.frag_index = 16'($urandom_range(0, 7));
                        it.frag_total = 16'($urandom_range(1, 8));
                        it.command = frt_pkg::CMD_ADD;
                        send_request(it);
                    end
                    1: clean_up(clock_ms + $urandom_range(0, 3000));
                    default: send_message(16'($urandom_range(1, (m % 9 == 0) ? 32 : 6)), m % 2);
                endcase
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0) $display("tb_fragment_reassembly_tracker OK");
        else $display("tb_fragment_reassembly_tracker NOT OK");
        $finish;
    end
endmodule
